[src/bmhq_pkg.sv]
// Shared types and constants for the binary min-heap queue.
package bmhq_pkg;

    localparam int KEY_W    = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_UPDATE = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEL_LD,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_L,
        S_DN_R,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_res;

endpackage

[src/bmhq_if.sv]
// Valid/ready channel interfaces for heap operations and their results.
interface bmhq_item_if import bmhq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    t_key              key_value;
    t_key              new_key;

    modport source (output valid, kind, key_value, new_key, input ready);
    modport sink   (input valid, kind, key_value, new_key, output ready);
endinterface

interface bmhq_res_if import bmhq_pkg::*; ();
    logic                valid;
    logic                ready;
    t_key                removed_key;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, removed_key, status, entry_count, input ready);
    modport sink   (input valid, removed_key, status, entry_count, output ready);
endinterface

[src/binary_min_heap_queue.sv]
// Binary min-heap queue; one item at a time, the next is taken once the result has loaded.
// Insert: S_UP_RD, S_UP_CMP per parent, S_WRITE. Errors and kind 3: result loads at accept.
// Delete: S_DEL_LD, then S_DN_RD, S_DN_L, S_DN_R per level descended; at the node it stops at,
// S_DN_RD, plus S_DN_L and S_DN_R when it has a child, then S_WRITE. Update: S_SRCH_RD and
// S_SRCH_CMP per entry searched; a hit runs S_UP_RD, S_UP_CMP per parent, then that sift down.
// Reset clears the count and control only; storage holds no reset value.
module binary_min_heap_queue import bmhq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bmhq_item_if.sink    i_item,
    bmhq_res_if.source   o_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = AW + 2;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_pos, n_pos;
    logic [AW-1:0]     r_idx, n_idx;
    t_key              r_key, n_key;
    t_key              r_nkey, n_nkey;
    t_key              r_right, n_right;
    t_key              r_best, n_best;
    logic              r_best_lc, n_best_lc;
    t_key              r_removed, n_removed;
    logic              r_upd, n_upd;

    logic              r_o_valid;
    t_key              r_o_removed;
    t_status           r_o_status;
    logic [COUNT_W-1:0] r_o_count;

    logic              w_take;
    logic              w_acc;
    logic              w_out_ld;
    t_status           w_out_status;
    t_key              w_out_removed;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    t_key              w_wdata;
    logic [AW-1:0]     w_raddr_a;
    logic [AW-1:0]     w_raddr_b;
    t_key              w_rd_a;
    t_key              w_rd_b;

    t_key              w_cmp_a;
    t_key              w_cmp_b;
    t_cmp_res          w_cmp;

    logic [WW-1:0]     w_pos_x;
    logic [WW-1:0]     w_cnt_x;
    logic [WW-1:0]     w_lc;
    logic [WW-1:0]     w_rc;
    logic              w_lc_ok;
    logic              w_rc_ok;
    logic [AW-1:0]     w_parent;
    logic [WW-1:0]     w_idx_nx;
    logic [CW-1:0]     w_cnt_m1;
    logic [CW+COUNT_W-1:0] w_cnt_wide;
    t_state            w_up_done;

    bmhq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    bmhq_cmp u_cmp (
        .i_a   (w_cmp_a),
        .i_b   (w_cmp_b),
        .o_res (w_cmp)
    );

    // Child and parent indices of the hole being moved.
    assign w_pos_x    = WW'(r_pos);
    assign w_cnt_x    = WW'(r_count);
    assign w_lc       = {w_pos_x[WW-2:0], 1'b1};
    assign w_rc       = w_lc + WW'(1);
    assign w_lc_ok    = (w_lc < w_cnt_x);
    assign w_rc_ok    = (w_rc < w_cnt_x);
    assign w_parent   = (r_pos - AW'(1)) >> 1;
    assign w_idx_nx   = WW'(r_idx) + WW'(1);
    assign w_cnt_m1   = r_count - CW'(1);
    assign w_cnt_wide = {{COUNT_W{1'b0}}, r_count};
    assign w_up_done  = r_upd ? S_DN_RD : S_WRITE;

    assign w_take       = (r_state == S_IDLE) && (!r_o_valid || o_res.ready);
    assign w_acc        = w_take && i_item.valid;
    assign i_item.ready = w_take;

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_pos         = r_pos;
        n_idx         = r_idx;
        n_key         = r_key;
        n_nkey        = r_nkey;
        n_right       = r_right;
        n_best        = r_best;
        n_best_lc     = r_best_lc;
        n_removed     = r_removed;
        n_upd         = r_upd;
        w_out_ld      = 1'b0;
        w_out_status  = ST_OK;
        w_out_removed = '0;
        w_we          = 1'b0;
        w_waddr       = r_pos;
        w_wdata       = r_key;
        w_raddr_a     = r_idx;
        w_raddr_b     = '0;
        w_cmp_a       = w_rd_a;
        w_cmp_b       = r_key;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_key     = i_item.key_value;
                    n_nkey    = i_item.new_key;
                    n_removed = '0;
                    n_upd     = 1'b0;
                    unique case (i_item.kind)
                        KIND_INSERT: begin
                            if (w_cnt_x >= WW'(CAPACITY)) begin
                                w_out_ld     = 1'b1;
                                w_out_status = ST_FULL;
                            end else begin
                                n_pos   = r_count[AW-1:0];
                                n_count = r_count + CW'(1);
                                n_state = (r_count == '0) ? S_WRITE : S_UP_RD;
                            end
                        end
                        KIND_DELETE: begin
                            if (r_count == '0) begin
                                w_out_ld     = 1'b1;
                                w_out_status = ST_EMPTY;
                            end else begin
                                // fetch root and last entry together
                                n_count   = w_cnt_m1;
                                w_raddr_a = '0;
                                w_raddr_b = w_cnt_m1[AW-1:0];
                                n_state   = S_DEL_LD;
                            end
                        end
                        KIND_UPDATE: begin
                            if (r_count == '0) begin
                                w_out_ld     = 1'b1;
                                w_out_status = ST_NOTFOUND;
                            end else begin
                                n_idx   = '0;
                                n_upd   = 1'b1;
                                n_state = S_SRCH_RD;
                            end
                        end
                        default: begin
                            w_out_ld     = 1'b1;
                            w_out_status = ST_OK;
                        end
                    endcase
                end
            end
            S_DEL_LD: begin
                n_removed = w_rd_a;
                n_key     = w_rd_b;
                n_pos     = '0;
                n_state   = S_DN_RD;
            end
            S_SRCH_RD: begin
                w_raddr_a = r_idx;
                n_state   = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                w_cmp_a = w_rd_a;
                w_cmp_b = r_key;
                if (w_cmp.eq) begin
                    n_key   = r_nkey;
                    n_pos   = r_idx;
                    n_state = (r_idx == '0) ? S_DN_RD : S_UP_RD;
                end else if (w_idx_nx >= w_cnt_x) begin
                    w_out_ld     = 1'b1;
                    w_out_status = ST_NOTFOUND;
                    n_state      = S_IDLE;
                end else begin
                    n_idx   = w_idx_nx[AW-1:0];
                    n_state = S_SRCH_RD;
                end
            end
            S_UP_RD: begin
                w_raddr_a = w_parent;
                n_state   = S_UP_CMP;
            end
            S_UP_CMP: begin
                w_cmp_a = r_key;
                w_cmp_b = w_rd_a;
                if (w_cmp.lt) begin
                    // drop the parent into the hole and climb
                    w_we    = 1'b1;
                    w_waddr = r_pos;
                    w_wdata = w_rd_a;
                    n_pos   = w_parent;
                    n_state = (w_parent == '0) ? w_up_done : S_UP_RD;
                end else begin
                    n_state = w_up_done;
                end
            end
            S_DN_RD: begin
                w_raddr_a = w_lc[AW-1:0];
                w_raddr_b = w_rc[AW-1:0];
                n_state   = w_lc_ok ? S_DN_L : S_WRITE;
            end
            S_DN_L: begin
                w_cmp_a = w_rd_a;
                w_cmp_b = r_key;
                n_right = w_rd_b;
                if (w_cmp.lt) begin
                    n_best    = w_rd_a;
                    n_best_lc = 1'b1;
                end else begin
                    n_best    = r_key;
                    n_best_lc = 1'b0;
                end
                n_state = S_DN_R;
            end
            S_DN_R: begin
                // left child wins a tie with the right
                w_cmp_a = r_right;
                w_cmp_b = r_best;
                if (w_rc_ok && w_cmp.lt) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos;
                    w_wdata = r_right;
                    n_pos   = w_rc[AW-1:0];
                    n_state = S_DN_RD;
                end else if (r_best_lc) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos;
                    w_wdata = r_best;
                    n_pos   = w_lc[AW-1:0];
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                w_we          = 1'b1;
                w_waddr       = r_pos;
                w_wdata       = r_key;
                w_out_ld      = 1'b1;
                w_out_status  = ST_OK;
                w_out_removed = r_removed;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_out_ld) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_idx     <= n_idx;
        r_key     <= n_key;
        r_nkey    <= n_nkey;
        r_right   <= n_right;
        r_best    <= n_best;
        r_best_lc <= n_best_lc;
        r_removed <= n_removed;
        r_upd     <= n_upd;
        if (w_out_ld) begin
            r_o_removed <= w_out_removed;
            r_o_status  <= w_out_status;
            r_o_count   <= w_cnt_wide[COUNT_W-1:0];
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.removed_key = r_o_removed;
    assign o_res.status      = r_o_status;
    assign o_res.entry_count = r_o_count;

endmodule

[src/bmhq_cmp.sv]
// Shared signed key comparator used by every search and sift step.
module bmhq_cmp import bmhq_pkg::*; (
    input  t_key     i_a,
    input  t_key     i_b,
    output t_cmp_res o_res
);

    assign o_res.lt = (i_a < i_b);
    assign o_res.eq = (i_a == i_b);

endmodule

[src/bmhq_store.sv]
// Heap key storage: one write port and two registered read ports.
module bmhq_store import bmhq_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_key          i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output t_key          o_rdata_a,
    output t_key          o_rdata_b
);

    t_key r_mem [DEPTH];
    t_key r_rd_a;
    t_key r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

[src/bmhq_chk.sv]
// Port-level assertions for the binary min-heap queue, bound to the top level.
module bmhq_chk import bmhq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input t_key                i_removed_key,
    input logic [STATUS_W-1:0] i_status,
    input logic [COUNT_W-1:0]  i_entry_count
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic [1:0] r_pend, n_pend;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;
    assign n_pend    = r_pend + 2'(w_in_acc) - 2'(w_out_acc);

    // track beats accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    a_one_outstanding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> (r_pend == 2'(w_out_acc)))
        else $error("item accepted while an earlier result is still owed");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == ST_EMPTY)) |->
            ((i_removed_key == '0) && (i_entry_count == '0)))
        else $error("empty status with nonzero key or count");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == ST_FULL)) |->
            (i_entry_count == COUNT_W'(CAPACITY)))
        else $error("full status with count below capacity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_removed_key) && $stable(i_status)
             && $stable(i_entry_count)))
        else $error("stalled result beat changed");

endmodule

bind binary_min_heap_queue bmhq_chk #(
    .CAPACITY (CAPACITY)
) u_bmhq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_removed_key (o_res.removed_key),
    .i_status      (o_res.status),
    .i_entry_count (o_res.entry_count)
);
